// ----- rtl/qpm_pkg.sv -----
// shared types, constants and helpers for the quad pid motor mixer
`timescale 1ns / 1ps

package qpm_pkg;

	// field and datapath widths
	localparam int STICK_W = 12;
	localparam int ANGLE_W = 17;
	localparam int GAIN_W  = 16;
	localparam int MOTOR_W = 12;
	localparam int ERR_W   = 18;
	localparam int DIF_W   = 19;
	localparam int SUM_W   = 32;
	localparam int ACC_W   = 18;
	localparam int TERM_W  = 16;
	localparam int MUL_A_W = 23;
	localparam int MUL_B_W = 33;
	localparam int PROD_W  = MUL_A_W + 1 + MUL_B_W;
	localparam int STEP_W  = 3;
	localparam int CFG_IDX_W = 3;

	// stick center and reciprocal of 100/768 scaled by 2^TGT_SHIFT, rounded up
	localparam logic [STICK_W-1:0] STICK_CENTER = 12'd1500;
	localparam logic [MUL_A_W-1:0] TGT_RECIP    = 23'd8053064;
	localparam int                 TGT_SHIFT    = 20;
	localparam int                 TGT_MAG_W    = 15;

	// last step of the multiply schedule
	localparam logic [STEP_W-1:0] LAST_STEP = 3'd7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MAX = 3'd4;

	// register reset values
	localparam logic [GAIN_W-1:0]  RESET_KP        = 16'd896;
	localparam logic [GAIN_W-1:0]  RESET_KI        = 16'd0;
	localparam logic [GAIN_W-1:0]  RESET_KD        = 16'd7680;
	localparam logic [MOTOR_W-1:0] RESET_MOTOR_MIN = 12'd1000;
	localparam logic [MOTOR_W-1:0] RESET_MOTOR_MAX = 12'd2000;

	// multiply operations, in schedule order
	typedef enum logic [1:0] {
		OP_TGT,
		OP_P,
		OP_I,
		OP_D
	} mul_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_MIX
	} fsm_state_t;

	// tag that travels with a product
	typedef struct packed {
		logic    vld;
		mul_op_t op;
		logic    axis;
	} mul_tag_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic    ready;
		logic    take;
		logic    issue;
		mul_op_t op;
		logic    axis;
		logic    emit;
	} seq_ctrl_t;

	// saturate an accumulated pid value to 16 signed bits
	function automatic logic signed [TERM_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-TERM_W:0] hi;
		logic                  fits;
		hi   = v[ACC_W-1:TERM_W-1];
		fits = (&hi) | (~|hi);
		if (fits) begin
			return v[TERM_W-1:0];
		end
		return v[ACC_W-1] ? 16'sh8000 : 16'sh7fff;
	endfunction

endpackage

// ----- rtl/qpm_mul.sv -----
// shared registered multiplier with operation tag
`timescale 1ns / 1ps

module qpm_mul
	import qpm_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      go,
	input  mul_op_t                   op,
	input  logic                      axis,
	input  logic [MUL_A_W-1:0]        a,
	input  logic signed [MUL_B_W-1:0] b,
	output logic signed [PROD_W-1:0]  prod_s1,
	output mul_tag_t                  tag_s1
);

	logic signed [PROD_W-1:0] prod;

	// unsigned a times signed b
	assign prod = $signed({1'b0, a}) * b;

	// product register
	always_ff @(posedge clk) begin
		if (go) begin
			prod_s1 <= prod;
		end
	end

	// tag register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '{vld: 1'b0, op: OP_TGT, axis: 1'b0};
		end else begin
			tag_s1 <= '{vld: go, op: op, axis: axis};
		end
	end

endmodule

// ----- rtl/qpm_seq.sv -----
// sequencer that schedules the shared multiplier and the output write
`timescale 1ns / 1ps

module qpm_seq
	import qpm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	output seq_ctrl_t ctrl
);

	fsm_state_t        state_q;
	fsm_state_t        state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              take;

	assign take = in_valid && ((state_q == ST_IDLE) || ((state_q == ST_MIX) && out_free));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (step_q == LAST_STEP) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_nxt = ST_MIX;
			end
			ST_MIX: begin
				if (out_free) begin
					state_nxt = take ? ST_RUN : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctrl.ready = 1'b0;
		ctrl.take  = take;
		ctrl.issue = 1'b0;
		ctrl.op    = mul_op_t'(step_q[2:1]);
		ctrl.axis  = step_q[0];
		ctrl.emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctrl.ready = 1'b1;
			end
			ST_RUN: begin
				ctrl.issue = 1'b1;
			end
			ST_DRAIN: begin
				ctrl.issue = 1'b0;
			end
			ST_MIX: begin
				ctrl.ready = out_free;
				ctrl.emit  = out_free;
			end
			default: begin
				ctrl.ready = 1'b0;
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_RUN) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

`ifndef SYNTHESIS
	a_run_ends_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == LAST_STEP) |=> (state_q == ST_DRAIN))
		else $error("multiply schedule did not end in drain");
	a_drain_to_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_MIX && step_q == '0))
		else $error("drain not followed by mix");
	a_take_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == ST_RUN && step_q == '0))
		else $error("accepted item did not start the schedule");
`endif

endmodule

// ----- rtl/qpm_mix.sv -----
// x-frame mixer with motor clamp
`timescale 1ns / 1ps

module qpm_mix
	import qpm_pkg::*;
(
	input  logic [STICK_W-1:0]      thr,
	input  logic signed [ACC_W-1:0] pitch_acc,
	input  logic signed [ACC_W-1:0] roll_acc,
	input  logic [MOTOR_W-1:0]      motor_min,
	input  logic [MOTOR_W-1:0]      motor_max,
	output logic [MOTOR_W-1:0]      front_left,
	output logic [MOTOR_W-1:0]      front_right,
	output logic [MOTOR_W-1:0]      rear_left,
	output logic [MOTOR_W-1:0]      rear_right
);

	localparam int MIX_W = TERM_W + 3;

	logic signed [TERM_W-1:0] p;
	logic signed [TERM_W-1:0] r;
	logic signed [MIX_W-1:0]  t;
	logic signed [MIX_W-1:0]  pe;
	logic signed [MIX_W-1:0]  re;

	// lower clamp first, then upper clamp
	function automatic logic [MOTOR_W-1:0] clamp(input logic signed [MIX_W-1:0] v,
			input logic [MOTOR_W-1:0] lo, input logic [MOTOR_W-1:0] hi);
		logic signed [MIX_W-1:0] x;
		x = v;
		if (x < $signed({{(MIX_W-MOTOR_W){1'b0}}, lo})) begin
			x = $signed({{(MIX_W-MOTOR_W){1'b0}}, lo});
		end
		if (x > $signed({{(MIX_W-MOTOR_W){1'b0}}, hi})) begin
			x = $signed({{(MIX_W-MOTOR_W){1'b0}}, hi});
		end
		return x[MOTOR_W-1:0];
	endfunction

	// saturated pid outputs
	assign p  = sat_acc(pitch_acc);
	assign r  = sat_acc(roll_acc);
	assign t  = $signed({{(MIX_W-STICK_W){1'b0}}, thr});
	assign pe = {{(MIX_W-TERM_W){p[TERM_W-1]}}, p};
	assign re = {{(MIX_W-TERM_W){r[TERM_W-1]}}, r};

	// four motors
	assign front_left  = clamp(t - pe + re, motor_min, motor_max);
	assign front_right = clamp(t - pe - re, motor_min, motor_max);
	assign rear_left   = clamp(t + pe + re, motor_min, motor_max);
	assign rear_right  = clamp(t + pe - re, motor_min, motor_max);

endmodule

// ----- rtl/quad_pid_motor_mixer.sv -----
// top level: two-axis pid attitude controller and x-frame motor mixer
// schedule: eight products go through one shared multiplier, then the drain and mix states follow;
//   the next item is taken in the mix state, once the output is free
// reset: gains and motor limits to defaults, error history and sums to zero, output empty
`timescale 1ns / 1ps

module quad_pid_motor_mixer
	import qpm_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [STICK_W-1:0]          throttle_stick,
	input  logic [STICK_W-1:0]          pitch_stick,
	input  logic [STICK_W-1:0]          roll_stick,
	input  logic signed [ANGLE_W-1:0]   pitch_angle,
	input  logic signed [ANGLE_W-1:0]   roll_angle,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [MOTOR_W-1:0]          motor_front_left,
	output logic [MOTOR_W-1:0]          motor_front_right,
	output logic [MOTOR_W-1:0]          motor_rear_left,
	output logic [MOTOR_W-1:0]          motor_rear_right,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [GAIN_W-1:0]           cfg_data
);

	localparam int QUO_W = PROD_W - 16;

	seq_ctrl_t ctrl;
	logic      out_free;
	logic      out_valid_q;

	// configuration
	logic [GAIN_W-1:0]  kp_q;
	logic [GAIN_W-1:0]  ki_q;
	logic [GAIN_W-1:0]  kd_q;
	logic [MOTOR_W-1:0] motor_min_q;
	logic [MOTOR_W-1:0] motor_max_q;

	// latched item
	logic [STICK_W-1:0]        thr_q;
	logic [STICK_W-1:0]        p_stick_q;
	logic [STICK_W-1:0]        r_stick_q;
	logic signed [ANGLE_W-1:0] p_angle_q;
	logic signed [ANGLE_W-1:0] r_angle_q;

	// per-axis state
	logic signed [ERR_W-1:0] p_err_q;
	logic signed [ERR_W-1:0] r_err_q;
	logic signed [ERR_W-1:0] p_prev_q;
	logic signed [ERR_W-1:0] r_prev_q;
	logic signed [SUM_W-1:0] p_sum_q;
	logic signed [SUM_W-1:0] r_sum_q;
	logic signed [DIF_W-1:0] p_dif_q;
	logic signed [DIF_W-1:0] r_dif_q;
	logic signed [ACC_W-1:0] p_acc_q;
	logic signed [ACC_W-1:0] r_acc_q;

	// output register
	logic [MOTOR_W-1:0] fl_q;
	logic [MOTOR_W-1:0] fr_q;
	logic [MOTOR_W-1:0] rl_q;
	logic [MOTOR_W-1:0] rr_q;
	logic [MOTOR_W-1:0] fl_mix;
	logic [MOTOR_W-1:0] fr_mix;
	logic [MOTOR_W-1:0] rl_mix;
	logic [MOTOR_W-1:0] rr_mix;

	// issue side
	logic [STICK_W-1:0]         cur_stick;
	logic signed [ERR_W-1:0]    cur_err;
	logic signed [ERR_W-1:0]    cur_prev;
	logic signed [SUM_W-1:0]    cur_sum;
	logic signed [DIF_W-1:0]    cur_dif;
	logic signed [STICK_W:0]    stick_d;
	logic signed [STICK_W:0]    stick_d_neg;
	logic [STICK_W-1:0]         stick_abs;
	logic signed [SUM_W:0]      sum_wide;
	logic signed [SUM_W-1:0]    sum_sat;
	logic signed [DIF_W-1:0]    dif_new;
	logic [MUL_A_W-1:0]         mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;

	// product side
	logic signed [PROD_W-1:0]   prod_s1;
	mul_tag_t                   tag_s1;
	logic [STICK_W-1:0]         rsp_stick;
	logic signed [ANGLE_W-1:0]  rsp_angle;
	logic signed [ACC_W-1:0]    rsp_acc;
	logic [TGT_MAG_W-1:0]       tgt_mag;
	logic signed [TERM_W-1:0]   tgt;
	logic signed [ERR_W-1:0]    err_new;
	logic signed [PROD_W-1:0]   prod_adj;
	logic signed [QUO_W-1:0]    quo;
	logic [QUO_W-TERM_W:0]      quo_hi;
	logic signed [TERM_W-1:0]   term;
	logic signed [ACC_W-1:0]    term_ext;
	logic signed [ACC_W-1:0]    acc_new;

	// handshakes
	assign in_stall  = !ctrl.ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	assign motor_front_left  = fl_q;
	assign motor_front_right = fr_q;
	assign motor_rear_left   = rl_q;
	assign motor_rear_right  = rr_q;

	qpm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= RESET_KP;
			ki_q        <= RESET_KI;
			kd_q        <= RESET_KD;
			motor_min_q <= RESET_MOTOR_MIN;
			motor_max_q <= RESET_MOTOR_MAX;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KP:        kp_q        <= cfg_data;
				REG_KI:        ki_q        <= cfg_data;
				REG_KD:        kd_q        <= cfg_data;
				REG_MOTOR_MIN: motor_min_q <= cfg_data[MOTOR_W-1:0];
				REG_MOTOR_MAX: motor_max_q <= cfg_data[MOTOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input latch on transfer
	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			thr_q     <= throttle_stick;
			p_stick_q <= pitch_stick;
			r_stick_q <= roll_stick;
			p_angle_q <= pitch_angle;
			r_angle_q <= roll_angle;
		end
	end

	// operand select for the scheduled axis
	assign cur_stick = ctrl.axis ? r_stick_q : p_stick_q;
	assign cur_err   = ctrl.axis ? r_err_q   : p_err_q;
	assign cur_prev  = ctrl.axis ? r_prev_q  : p_prev_q;
	assign cur_sum   = ctrl.axis ? r_sum_q   : p_sum_q;
	assign cur_dif   = ctrl.axis ? r_dif_q   : p_dif_q;

	// stick offset magnitude
	assign stick_d     = $signed({1'b0, cur_stick}) - $signed({1'b0, STICK_CENTER});
	assign stick_d_neg = -stick_d;
	assign stick_abs   = stick_d[STICK_W] ? stick_d_neg[STICK_W-1:0] : stick_d[STICK_W-1:0];

	// saturating error sum and error difference
	assign sum_wide = {cur_sum[SUM_W-1], cur_sum} + {{(SUM_W+1-ERR_W){cur_err[ERR_W-1]}}, cur_err};
	assign sum_sat  = (sum_wide[SUM_W] != sum_wide[SUM_W-1]) ?
		(sum_wide[SUM_W] ? 32'sh80000000 : 32'sh7fffffff) : sum_wide[SUM_W-1:0];
	assign dif_new  = {cur_err[ERR_W-1], cur_err} - {cur_prev[ERR_W-1], cur_prev};

	// multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctrl.op)
			OP_TGT: begin
				mul_a = TGT_RECIP;
				mul_b = $signed({{(MUL_B_W-STICK_W){1'b0}}, stick_abs});
			end
			OP_P: begin
				mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, kp_q};
				mul_b = {{(MUL_B_W-ERR_W){cur_err[ERR_W-1]}}, cur_err};
			end
			OP_I: begin
				mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, ki_q};
				mul_b = {{(MUL_B_W-SUM_W){cur_sum[SUM_W-1]}}, cur_sum};
			end
			OP_D: begin
				mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, kd_q};
				mul_b = {{(MUL_B_W-DIF_W){cur_dif[DIF_W-1]}}, cur_dif};
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	qpm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (ctrl.issue),
		.op      (ctrl.op),
		.axis    (ctrl.axis),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1),
		.tag_s1  (tag_s1)
	);

	// history update when the proportional product is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_prev_q <= '0;
			r_prev_q <= '0;
			p_sum_q  <= '0;
			r_sum_q  <= '0;
		end else if (ctrl.issue && ctrl.op == OP_P) begin
			if (ctrl.axis) begin
				r_sum_q  <= sum_sat;
				r_prev_q <= cur_err;
			end else begin
				p_sum_q  <= sum_sat;
				p_prev_q <= cur_err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.issue && ctrl.op == OP_P) begin
			if (ctrl.axis) begin
				r_dif_q <= dif_new;
			end else begin
				p_dif_q <= dif_new;
			end
		end
	end

	// product side select
	assign rsp_stick = tag_s1.axis ? r_stick_q : p_stick_q;
	assign rsp_angle = tag_s1.axis ? r_angle_q : p_angle_q;
	assign rsp_acc   = tag_s1.axis ? r_acc_q   : p_acc_q;

	// target angle and error
	assign tgt_mag = prod_s1[TGT_SHIFT+TGT_MAG_W-1:TGT_SHIFT];
	assign tgt     = (rsp_stick < STICK_CENTER) ? -$signed({1'b0, tgt_mag}) :
		$signed({1'b0, tgt_mag});
	assign err_new = {rsp_angle[ANGLE_W-1], rsp_angle} -
		{{(ERR_W-TERM_W){tgt[TERM_W-1]}}, tgt};

	// pid term: divide by 65536 toward zero, saturate to 16 bits
	assign prod_adj = prod_s1 + $signed({{(PROD_W-16){1'b0}}, {16{prod_s1[PROD_W-1]}}});
	assign quo      = prod_adj[PROD_W-1:16];
	assign quo_hi   = quo[QUO_W-1:TERM_W-1];
	assign term     = ((&quo_hi) | (~|quo_hi)) ? quo[TERM_W-1:0] :
		(quo[QUO_W-1] ? 16'sh8000 : 16'sh7fff);
	assign term_ext = {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};
	assign acc_new  = (tag_s1.op == OP_P) ? term_ext : rsp_acc + term_ext;

	// error and accumulator writes from the product
	always_ff @(posedge clk) begin
		if (tag_s1.vld) begin
			case (tag_s1.op)
				OP_TGT: begin
					if (tag_s1.axis) begin
						r_err_q <= err_new;
					end else begin
						p_err_q <= err_new;
					end
				end
				OP_P, OP_I, OP_D: begin
					if (tag_s1.axis) begin
						r_acc_q <= acc_new;
					end else begin
						p_acc_q <= acc_new;
					end
				end
				default: begin
				end
			endcase
		end
	end

	qpm_mix u_mix (
		.thr         (thr_q),
		.pitch_acc   (p_acc_q),
		.roll_acc    (r_acc_q),
		.motor_min   (motor_min_q),
		.motor_max   (motor_max_q),
		.front_left  (fl_mix),
		.front_right (fr_mix),
		.rear_left   (rl_mix),
		.rear_right  (rr_mix)
	);

	// output register
	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			fl_q <= fl_mix;
			fr_q <= fr_mix;
			rl_q <= rl_mix;
			rr_q <= rr_mix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again while an item is in work");
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> (!out_valid_q || !out_stall))
		else $error("result written over a pending transfer");
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctrl.emit))
		else $error("output valid without a mix write");
`endif

endmodule
